// ----- rtl/tcct_pkg.sv -----
`timescale 1ns / 1ps

package tcct_pkg;

  localparam int MsW    = 16;
  localparam int CountW = 13;
  localparam int ChanW  = 4;
  localparam int WordW  = 18;

  localparam logic [MsW-1:0] MS_MAX     = 16'd59999;
  localparam logic [4:0]     FAST_MATCH = 5'h10;

  // instruction word bits 10..6 select the command
  localparam logic [4:0] SEL_SET_CLOCK = 5'b10000;
  localparam logic [4:0] SEL_SET_COUNT = 5'b10001;

  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_ACCESS = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [WordW-1:0] instr_word;
    logic [WordW-1:0] acc_in;
    logic             wants_completion;
    logic             pulse_phase;
  } in_word_t;

  typedef struct packed {
    logic              io_write;
    logic [MsW-1:0]    io_value;
    logic              acc_write;
    logic [CountW-1:0] acc_value;
    logic              clock_break;
    logic [ChanW-1:0]  clock_break_channel;
    logic              timer_break;
    logic [ChanW-1:0]  timer_break_channel;
    logic              complete;
    logic              sbs16_set;
    logic              done_flag;
  } out_word_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } flow_t;

endpackage

// ----- rtl/tcct_if.sv -----
`timescale 1ns / 1ps

interface tcct_in_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [tcct_pkg::WordW-1:0] instr_word;
  logic [tcct_pkg::WordW-1:0] acc_in;
  logic                     wants_completion;
  logic                     pulse_phase;

  modport source (output valid, mode, instr_word, acc_in, wants_completion, pulse_phase,
                  input ready);
  modport sink (input valid, mode, instr_word, acc_in, wants_completion, pulse_phase,
                output ready);
  modport monitor (input valid, ready, mode, instr_word, acc_in, wants_completion,
                   pulse_phase);
endinterface

interface tcct_out_if;
  logic                        valid;
  logic                        ready;
  logic                        io_write;
  logic [tcct_pkg::MsW-1:0]    io_value;
  logic                        acc_write;
  logic [tcct_pkg::CountW-1:0] acc_value;
  logic                        clock_break;
  logic [tcct_pkg::ChanW-1:0]  clock_break_channel;
  logic                        timer_break;
  logic [tcct_pkg::ChanW-1:0]  timer_break_channel;
  logic                        complete;
  logic                        sbs16_set;
  logic                        done_flag;

  modport source (output valid, io_write, io_value, acc_write, acc_value, clock_break,
                  clock_break_channel, timer_break, timer_break_channel, complete,
                  sbs16_set, done_flag,
                  input ready);
  modport sink (input valid, io_write, io_value, acc_write, acc_value, clock_break,
                clock_break_channel, timer_break, timer_break_channel, complete,
                sbs16_set, done_flag,
                output ready);
  modport monitor (input valid, ready, io_write, io_value, acc_write, acc_value,
                   clock_break, clock_break_channel, timer_break, timer_break_channel,
                   complete, sbs16_set, done_flag);
endinterface

// ----- rtl/timeshare_clock_countdown_timer.sv -----
`timescale 1ns / 1ps
// An accepted word waits in the input register until the result register is free.
// One word per cycle while results are taken, set by the single state update in the core.
// Input and result registers part the two channels; ready falls only when both are full.
// Reset (synchronous, rst_n low) stops the clock, clears all counters, channels, enables,
// pending completions and the done flag, and empties both registers.

module timeshare_clock_countdown_timer (
  input  logic              clk,
  input  logic              rst_n,
  tcct_in_if.sink           in_ch,
  tcct_out_if.source        out_ch
);

  tcct_pkg::in_word_t  in_data;
  tcct_pkg::in_word_t  item;
  tcct_pkg::out_word_t res;
  tcct_pkg::out_word_t res_q;
  tcct_pkg::flow_t     flow;
  logic                step;

  assign in_data.mode             = in_ch.mode;
  assign in_data.instr_word       = in_ch.instr_word;
  assign in_data.acc_in           = in_ch.acc_in;
  assign in_data.wants_completion = in_ch.wants_completion;
  assign in_data.pulse_phase      = in_ch.pulse_phase;

  tcct_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_data  (in_data),
    .out_free (flow.out_free),
    .step     (step),
    .item     (item)
  );

  tcct_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (flow.in_valid),
    .item  (item),
    .res   (res)
  );

  tcct_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_in    (res),
    .flow      (flow),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .res_q     (res_q)
  );

  assign out_ch.io_write            = res_q.io_write;
  assign out_ch.io_value            = res_q.io_value;
  assign out_ch.acc_write           = res_q.acc_write;
  assign out_ch.acc_value           = res_q.acc_value;
  assign out_ch.clock_break         = res_q.clock_break;
  assign out_ch.clock_break_channel = res_q.clock_break_channel;
  assign out_ch.timer_break         = res_q.timer_break;
  assign out_ch.timer_break_channel = res_q.timer_break_channel;
  assign out_ch.complete            = res_q.complete;
  assign out_ch.sbs16_set           = res_q.sbs16_set;
  assign out_ch.done_flag           = res_q.done_flag;

endmodule

// ----- rtl/tcct_in_reg.sv -----
`timescale 1ns / 1ps

module tcct_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcct_pkg::in_word_t in_data,
  input  logic               out_free,
  output logic               step,
  output tcct_pkg::in_word_t item
);

  logic               valid_r;
  logic               valid_nxt;
  tcct_pkg::in_word_t data_r;

  assign step      = valid_r && out_free;
  assign in_ready  = !valid_r || out_free;
  assign valid_nxt = in_ready ? in_valid : valid_r;
  assign item      = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // hold the word until the core takes it
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

// ----- rtl/tcct_core.sv -----
`timescale 1ns / 1ps

module tcct_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  tcct_pkg::in_word_t  item,
  output tcct_pkg::out_word_t res
);

  logic                          clock_on_r, clock_on_nxt;
  logic [tcct_pkg::MsW-1:0]      ms_count_r, ms_count_nxt;
  logic                          fast_irq_on_r, fast_irq_on_nxt;
  logic [tcct_pkg::ChanW-1:0]    fast_irq_chan_r, fast_irq_chan_nxt;
  logic                          minute_irq_on_r, minute_irq_on_nxt;
  logic [tcct_pkg::ChanW-1:0]    minute_irq_chan_r, minute_irq_chan_nxt;
  logic                          clock_done_pending_r, clock_done_pending_nxt;
  logic [tcct_pkg::CountW-1:0]   down_count_r, down_count_nxt;
  logic                          timer_irq_on_r, timer_irq_on_nxt;
  logic [tcct_pkg::ChanW-1:0]    timer_irq_chan_r, timer_irq_chan_nxt;
  logic                          timer_done_pending_r, timer_done_pending_nxt;
  logic                          expired_r, expired_nxt;

  logic [4:0]                    sel;
  logic [3:0]                    op;
  logic [tcct_pkg::MsW-1:0]      ms_inc;
  logic                          fast_hit;
  logic                          wrap;
  logic                          minute_hit;
  logic [tcct_pkg::CountW-1:0]   down_dec;
  logic [tcct_pkg::CountW-1:0]   new_count;

  assign sel       = item.instr_word[10:6];
  assign op        = item.acc_in[11:8];
  assign ms_inc    = ms_count_r + tcct_pkg::MsW'(1);
  assign fast_hit  = fast_irq_on_r && (ms_inc[4:0] == tcct_pkg::FAST_MATCH);
  assign wrap      = ms_inc > tcct_pkg::MS_MAX;
  assign minute_hit = wrap && minute_irq_on_r;
  assign down_dec  = down_count_r - tcct_pkg::CountW'(1);
  assign new_count = item.acc_in[tcct_pkg::CountW-1:0];

  always_comb begin
    clock_on_nxt           = clock_on_r;
    ms_count_nxt           = ms_count_r;
    fast_irq_on_nxt        = fast_irq_on_r;
    fast_irq_chan_nxt      = fast_irq_chan_r;
    minute_irq_on_nxt      = minute_irq_on_r;
    minute_irq_chan_nxt    = minute_irq_chan_r;
    clock_done_pending_nxt = clock_done_pending_r;
    down_count_nxt         = down_count_r;
    timer_irq_on_nxt       = timer_irq_on_r;
    timer_irq_chan_nxt     = timer_irq_chan_r;
    timer_done_pending_nxt = timer_done_pending_r;
    expired_nxt            = expired_r;
    res                    = '0;

    if (item.mode == tcct_pkg::MODE_ACCESS) begin
      if (!item.pulse_phase) begin
        case (sel)
          tcct_pkg::SEL_SET_CLOCK: begin
            clock_on_nxt           = op[2];
            fast_irq_on_nxt        = op[2] && op[0];
            minute_irq_on_nxt      = op[2] && op[1];
            clock_done_pending_nxt = op[2] && !op[1] && !op[0] && item.wants_completion;
            if (op[2] && op[1]) begin
              minute_irq_chan_nxt = item.acc_in[7:4];
            end
            if (op[2] && op[0]) begin
              fast_irq_chan_nxt = item.acc_in[3:0];
            end
            res.sbs16_set = op[3];
          end
          tcct_pkg::SEL_SET_COUNT: begin
            expired_nxt    = 1'b0;
            down_count_nxt = new_count;
            if (new_count != '0) begin
              timer_done_pending_nxt = item.wants_completion;
              timer_irq_chan_nxt     = item.acc_in[16:13];
              timer_irq_on_nxt       = item.acc_in[17];
            end else begin
              timer_irq_on_nxt       = 1'b0;
              timer_done_pending_nxt = 1'b0;
            end
            res.acc_write = 1'b1;
            res.acc_value = down_count_r;
          end
          default: begin
            if (clock_on_r) begin
              res.io_write = 1'b1;
              res.io_value = ms_count_r;
            end
          end
        endcase
        res.complete = item.wants_completion && !clock_done_pending_nxt &&
                       !timer_done_pending_nxt;
      end
    end else begin
      if (clock_on_r) begin
        ms_count_nxt = wrap ? '0 : ms_inc;
        if (minute_hit) begin
          res.clock_break         = 1'b1;
          res.clock_break_channel = minute_irq_chan_r;
        end else if (fast_hit) begin
          res.clock_break         = 1'b1;
          res.clock_break_channel = fast_irq_chan_r;
        end
        if (minute_hit || fast_hit) begin
          clock_done_pending_nxt = 1'b0;
        end
        if (!fast_irq_on_r && !minute_irq_on_r) begin
          res.complete           = clock_done_pending_r;
          clock_done_pending_nxt = 1'b0;
        end
      end
      if (down_count_r != '0) begin
        down_count_nxt = down_dec;
        if (down_dec == '0) begin
          if (timer_irq_on_r) begin
            res.timer_break         = 1'b1;
            res.timer_break_channel = timer_irq_chan_r;
          end
          if (timer_done_pending_r) begin
            res.complete = 1'b1;
          end
          timer_done_pending_nxt = 1'b0;
          expired_nxt            = 1'b1;
        end
      end
    end

    res.done_flag = expired_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_on_r           <= 1'b0;
      ms_count_r           <= '0;
      fast_irq_on_r        <= 1'b0;
      fast_irq_chan_r      <= '0;
      minute_irq_on_r      <= 1'b0;
      minute_irq_chan_r    <= '0;
      clock_done_pending_r <= 1'b0;
      down_count_r         <= '0;
      timer_irq_on_r       <= 1'b0;
      timer_irq_chan_r     <= '0;
      timer_done_pending_r <= 1'b0;
      expired_r            <= 1'b0;
    end else if (step) begin
      clock_on_r           <= clock_on_nxt;
      ms_count_r           <= ms_count_nxt;
      fast_irq_on_r        <= fast_irq_on_nxt;
      fast_irq_chan_r      <= fast_irq_chan_nxt;
      minute_irq_on_r      <= minute_irq_on_nxt;
      minute_irq_chan_r    <= minute_irq_chan_nxt;
      clock_done_pending_r <= clock_done_pending_nxt;
      down_count_r         <= down_count_nxt;
      timer_irq_on_r       <= timer_irq_on_nxt;
      timer_irq_chan_r     <= timer_irq_chan_nxt;
      timer_done_pending_r <= timer_done_pending_nxt;
      expired_r            <= expired_nxt;
    end
  end

endmodule

// ----- rtl/tcct_out_reg.sv -----
`timescale 1ns / 1ps

module tcct_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  tcct_pkg::out_word_t res_in,
  output tcct_pkg::flow_t     flow,
  output logic                out_valid,
  input  logic                out_ready,
  output tcct_pkg::out_word_t res_q
);

  logic                valid_r;
  logic                valid_nxt;
  tcct_pkg::out_word_t data_r;

  assign flow.out_free = !valid_r || out_ready;
  assign flow.in_valid = load;
  assign valid_nxt     = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  assign out_valid     = valid_r;
  assign res_q         = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_in;
    end
  end

endmodule

// ----- rtl/tcct_checker.sv -----
`timescale 1ns / 1ps

module tcct_checker (
  input logic        clk,
  input logic        rst_n,
  tcct_in_if.sink    in_ch,
  tcct_out_if.source out_ch
);

  logic in_seen;

  assign in_seen = in_ch.valid && in_ch.ready;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped while stalled");

  a_clock_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.clock_break |-> out_ch.clock_break_channel == '0)
    else $error("clock channel without clock break");

  a_timer_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.timer_break |-> out_ch.timer_break_channel == '0)
    else $error("timer channel without timer break");

  a_timer_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.timer_break |-> out_ch.done_flag && !out_ch.acc_write)
    else $error("timer break without done flag");

  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_seen |=> ##1 out_ch.valid)
    else $error("accepted word gave no result");

endmodule

bind timeshare_clock_countdown_timer tcct_checker u_tcct_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
